// ----- rtl/sti_pkg.sv -----
// Types and constants shared by the sorted table modules.
package sti_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam int ENTRY_COUNT_W = 8;

  typedef struct packed {
    logic               cmd;
    logic [31:0]        key_id;
    logic signed [15:0] entry_score;
    logic [15:0]        record_ref;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [15:0] score;
    logic [15:0]        rec;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rm_start;
    logic scan;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- rtl/sti_cell.sv -----
// One table slot with its insert, match and close-gap logic.
module sti_cell (
  input  logic                clk,
  input  logic                rst,
  input  sti_pkg::cell_ctrl_t ctl,
  input  logic                occ,
  input  logic                at_end,
  input  sti_pkg::entry_t     new_entry,
  input  sti_pkg::entry_t     left_entry,
  input  logic                left_gt,
  input  logic                left_p,
  input  sti_pkg::entry_t     right_entry,
  output sti_pkg::entry_t     entry,
  output logic                gt,
  output logic                p
);
  import sti_pkg::*;

  logic m;

  // The first free slot counts as greater, so an entry larger than all others lands there.
  assign gt = (occ && ($signed(new_entry.score) < $signed(entry.score))) || at_end;

  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      entry <= left_gt ? left_entry : new_entry;
    end else if (ctl.shift && p) begin
      entry <= right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= 1'b0;
      p <= 1'b0;
    end else if (ctl.rm_start) begin
      m <= occ && (entry.id == new_entry.id);
      p <= 1'b0;
    end else if (ctl.scan) begin
      p <= left_p | m;
    end
  end

endmodule

// ----- rtl/sti_ctrl.sv -----
// Command sequencer, entry count and result register for the sorted table.
module sti_ctrl #(
  parameter int DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  sti_pkg::item_t                item,
  input  logic                          found,
  output logic                          busy,
  output logic [$clog2(DEPTH+1)-1:0]    count,
  output sti_pkg::cell_ctrl_t           ctl,
  output logic                          done,
  output sti_pkg::result_t              result
);
  import sti_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SCW = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]     state;
  logic [1:0]     state_next;
  logic [SCW-1:0] scan_cnt;
  logic           accept;
  logic           full;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));

  assign ctl.ins      = accept && (item.cmd == CMD_INSERT) && !full;
  assign ctl.rm_start = accept && (item.cmd == CMD_REMOVE);
  assign ctl.scan     = (state == S_SCAN);
  assign ctl.shift    = (state == S_SHIFT);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (ctl.rm_start) state_next = S_SCAN;
      S_SCAN:  if (scan_cnt == SCW'(DEPTH - 1)) state_next = S_SHIFT;
      S_SHIFT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (ctl.rm_start) begin
        scan_cnt <= '0;
      end else if (ctl.scan) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (accept && (item.cmd == CMD_INSERT)) begin
        done <= 1'b1;
        if (full) begin
          result.status <= STATUS_FULL;
          result.entry_count <= ENTRY_COUNT_W'(count);
        end else begin
          count <= count + 1'b1;
          result.status <= STATUS_DONE;
          result.entry_count <= ENTRY_COUNT_W'(count + 1'b1);
        end
      end else if (ctl.shift) begin
        done <= 1'b1;
        if (found) begin
          count <= count - 1'b1;
          result.status <= STATUS_DONE;
          result.entry_count <= ENTRY_COUNT_W'(count - 1'b1);
        end else begin
          result.status <= STATUS_NOT_FOUND;
          result.entry_count <= ENTRY_COUNT_W'(count);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_insert_result: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> done && (result.status == STATUS_DONE))
    else $error("accepted insert did not report done");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + 1'b1) || (count + 1'b1 == $past(count))))
    else $error("entry count moved by more than one");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && done) |-> $past((state == S_SHIFT) || (start && !busy)))
    else $error("result strobe without a finished command");
`endif

endmodule

// ----- rtl/sorted_table_insert_remove.sv -----
// Sorted table top level: a row of slot cells under one command sequencer.
//
// The table keeps up to TABLE_DEPTH entries in ascending score order; equal
// scores stay in arrival order. A beat is taken when start is high and busy
// is low, and its result appears on result with done high for exactly one
// cycle; the receiver cannot stall it. An insert is applied at the accepting
// edge, its result shows in the next cycle, and busy stays low, so inserts
// can be issued every cycle while no remove is busy. A remove first latches
// a match flag in every cell, then passes a first-match flag down the row of
// cells one cell per cycle, then closes the gap in the shift state; busy
// stays high until the gap is closed, and the result shows in the cycle
// busy falls. The length of the row of cells sets the remove time.
module sorted_table_insert_remove #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sti_pkg::item_t    item,
  output logic              done,
  output sti_pkg::result_t  result
);
  import sti_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0]        count;
  cell_ctrl_t           ctl;
  entry_t               new_entry;
  entry_t               entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt;
  logic [TABLE_DEPTH-1:0] p;

  assign new_entry.id    = item.key_id;
  assign new_entry.score = item.entry_score;
  assign new_entry.rec   = item.record_ref;

  sti_ctrl #(
    .DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .found  (p[TABLE_DEPTH-1]),
    .busy   (busy),
    .count  (count),
    .ctl    (ctl),
    .done   (done),
    .result (result)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   at_end;
    logic   left_gt;
    logic   left_p;
    entry_t left_entry;
    entry_t right_entry;

    assign occ    = (count > CW'(i));
    assign at_end = (count == CW'(i));

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_p     = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_inner
      assign left_gt    = gt[i-1];
      assign left_p     = p[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    sti_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .occ         (occ),
      .at_end      (at_end),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .left_p      (left_p),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .gt          (gt[i]),
      .p           (p[i])
    );
  end

endmodule

// ----- sim/sorted_table_checker.sv -----
// Checker that predicts the status and entry count of every sorted table beat and compares.
`timescale 1ns / 100ps
module sorted_table_checker #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  sti_pkg::item_t   item,
  input  logic             done,
  input  sti_pkg::result_t result,
  output int               errors,
  output int               pending
);
  import sti_pkg::*;

  logic [31:0]        tbl_id    [TABLE_DEPTH];
  logic signed [15:0] tbl_score [TABLE_DEPTH];
  logic [15:0]        tbl_rec   [TABLE_DEPTH];
  int                 held = 0;
  int                 mismatches = 0;
  result_t            predicted_outcomes [$];

  assign errors = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns sorted table mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one beat to the table copy and returns the status and count it yields.
  function automatic result_t table_apply(input item_t beat);
    result_t outcome;
    int      pos;
    int      hit;
    outcome.status = STATUS_DONE;
    if (beat.cmd == CMD_INSERT) begin
      if (held >= TABLE_DEPTH) begin
        outcome.status = STATUS_FULL;
      end else begin
        pos = held;
        while (pos > 0 && $signed(beat.entry_score) < $signed(tbl_score[pos-1])) begin
          tbl_id[pos]    = tbl_id[pos-1];
          tbl_score[pos] = tbl_score[pos-1];
          tbl_rec[pos]   = tbl_rec[pos-1];
          pos--;
        end
        tbl_id[pos]    = beat.key_id;
        tbl_score[pos] = beat.entry_score;
        tbl_rec[pos]   = beat.record_ref;
        held++;
      end
    end else begin
      hit = -1;
      for (int i = 0; i < held; i++) begin
        if (hit < 0 && tbl_id[i] == beat.key_id) begin
          hit = i;
        end
      end
      if (hit < 0) begin
        outcome.status = STATUS_NOT_FOUND;
      end else begin
        for (int i = hit; i + 1 < held; i++) begin
          tbl_id[i]    = tbl_id[i+1];
          tbl_score[i] = tbl_score[i+1];
          tbl_rec[i]   = tbl_rec[i+1];
        end
        held--;
      end
    end
    outcome.entry_count = held[ENTRY_COUNT_W-1:0];
    return outcome;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      held = 0;
      predicted_outcomes.delete();
      pending <= 0;
    end else begin
      if (done !== 1'b0) begin
        if (predicted_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with no beat outstanding, status %0d count %0d",
                                    result.status, result.entry_count));
        end else begin
          want = predicted_outcomes.pop_front();
          if (result.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, want.status));
          end
          if (result.entry_count !== want.entry_count) begin
            report_mismatch($sformatf("entry count %0d, expected %0d",
                                      result.entry_count, want.entry_count));
          end
        end
      end
      if (start && !busy) begin
        predicted_outcomes.push_back(table_apply(item));
      end
      pending <= predicted_outcomes.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Top level that drives insert and remove beats into the sorted table and gives the verdict.
`timescale 1ns / 100ps
module testbench;
  import sti_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int ITEM_TARGET = 1050;
  localparam int STALL_LIMIT = 20 * (TABLE_DEPTH + 4);

  logic        clk   = 1'b0;
  logic        rst   = 1'b1;
  logic        start = 1'b0;
  item_t       item  = '0;
  logic        busy;
  logic        done;
  result_t     result;
  int          errors;
  int          pending;
  int          beats_sent   = 0;
  int          idle_pct     = 0;
  int          quiet_cycles = 0;
  logic [31:0] live_ids [$];

  always #5 clk = ~clk;

  sorted_table_insert_remove #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  sorted_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) table_check (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result),
    .errors (errors),
    .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_id();
    return $urandom_range(1) ? 32'($urandom_range(15)) : 32'($urandom);
  endfunction

  function automatic logic [15:0] rand_score();
    case ($urandom_range(3))
      0: return 16'($urandom_range(8) - 4);
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic cmd, input logic [31:0] id,
                           input logic [15:0] score, input logic [15:0] rec);
    item_t beat;
    beat.cmd         = cmd;
    beat.key_id      = id;
    beat.entry_score = score;
    beat.record_ref  = rec;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= beat;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic insert_entry(input logic [31:0] id, input logic [15:0] score,
                              input logic [15:0] rec);
    send_beat(CMD_INSERT, id, score, rec);
    if (live_ids.size() < TABLE_DEPTH) begin
      live_ids.push_back(id);
    end
  endtask

  task automatic remove_id(input logic [31:0] id);
    int idx [$];
    send_beat(CMD_REMOVE, id, 16'($urandom), 16'($urandom));
    idx = live_ids.find_first_index(x) with (x == id);
    if (idx.size() > 0) begin
      live_ids.delete(idx[0]);
    end
  endtask

  // A miss uses an id above the small pool, so it almost never matches an entry.
  task automatic remove_entry(input bit hit);
    if (hit && live_ids.size() > 0) begin
      remove_id(live_ids[$urandom_range(live_ids.size() - 1)]);
    end else begin
      remove_id($urandom_range(1) ? 32'($urandom_range(31, 16)) : 32'($urandom));
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int episode;
    int floor_size;
    episode = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    remove_id(32'd5);
    insert_entry(32'd0, 16'h0000, 16'h0000);
    insert_entry(32'hffff_ffff, 16'h7fff, 16'hffff);
    insert_entry(32'd1, 16'h8000, 16'h1234);
    insert_entry(32'd2, 16'h0000, 16'h0005);
    insert_entry(32'd2, 16'hffff, 16'h0006);
    insert_entry(32'd3, 16'h0100, 16'h0007);
    insert_entry(32'd4, 16'h7fff, 16'h0008);
    remove_id(32'd2);
    remove_id(32'd2);
    remove_id(32'd2);
    remove_id(32'hffff_ffff);
    remove_id(32'd99);
    remove_id(32'd4);
    remove_id(32'd0);
    remove_id(32'd1);
    remove_id(32'd3);
    remove_id(32'd3);
    wait_quiet();

    while (beats_sent < ITEM_TARGET) begin
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 49;
        default: idle_pct = 18;
      endcase
      case (episode == 0 ? 0 : $urandom_range(3))
        0: begin
          while (live_ids.size() < TABLE_DEPTH) begin
            insert_entry(rand_id(), rand_score(), 16'($urandom));
          end
          repeat ($urandom_range(2, 5)) insert_entry(rand_id(), rand_score(), 16'($urandom));
        end
        1: begin
          floor_size = $urandom_range(1) ? 0 : $urandom_range(20);
          while (live_ids.size() > floor_size) begin
            remove_entry($urandom_range(9) != 0);
          end
          if (floor_size == 0) begin
            remove_entry(1'b0);
          end
        end
        default: begin
          repeat (60) begin
            if ($urandom_range(9) < 6) begin
              insert_entry(rand_id(), rand_score(), 16'($urandom));
            end else begin
              remove_entry($urandom_range(3) != 0);
            end
          end
        end
      endcase
      episode++;
      if ($urandom_range(3) == 0) begin
        wait_quiet();
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sti_pkg.sv
rtl/sti_cell.sv
rtl/sti_ctrl.sv
rtl/sorted_table_insert_remove.sv
sim/sorted_table_checker.sv
sim/testbench.sv
